FILE: rtl/odle_pkg.sv
// Package for the ordered deque list engine.
// Holds mode and status codes, the controller-datapath command set and shared types.
// No dependencies.
package odle_pkg;

	localparam int MODE_W = 4;
	localparam int POS_W  = 6;
	localparam int STAT_W = 3;

	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ORD_INS    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_REVERSE    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_READ       = 4'd8;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_BAD_POS   = 3'd4;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_CLEAR,
		CMD_REVERSE,
		CMD_SET_FULL,
		CMD_SET_EMPTY,
		CMD_SET_BADPOS,
		CMD_ALLOC,
		CMD_ALLOC_WR,
		CMD_GO_FRONT,
		CMD_GO_BACK,
		CMD_STEP,
		CMD_INS_A,
		CMD_INS_B,
		CMD_APPEND,
		CMD_REMOVE,
		CMD_NOTFOUND,
		CMD_HIT_READ,
		CMD_FIN
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              count_zero;
		logic              full;
		logic              pos_bad;
		logic              hit;
		logic              last;
		logic              idx_zero;
		logic              out_busy;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ALLOC,
		S_ALLOC_WR,
		S_WALK_GO,
		S_FRONT,
		S_WALK,
		S_INS_A,
		S_INS_B,
		S_APPEND,
		S_REMOVE,
		S_FIN
	} ctrl_state_t;

endpackage

FILE: rtl/ordered_deque_list_engine_unit.sv
// Ordered deque list engine: bounded doubly linked list of signed keys.
// Each request is accepted, decoded and finished through the result register; clear, reverse,
// rejected requests and unused modes do nothing more. Push and pop go straight to a list
// end; ordered insert, delete by key and read walk the list one link at a time (one key/link
// memory read each). One request at a time: the next is taken once the result is registered.
// Reset clears the list ends, count, direction and allocator; memories are not cleared.
module ordered_deque_list_engine_unit
	import odle_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32,
	localparam int CW      = $clog2(CAPACITY + 1),
	localparam int IN_W    = ((MODE_W + KEY_BITS + POS_W + 7) / 8) * 8,
	localparam int OUT_W   = ((STAT_W + CW + KEY_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // mode, key, position, zero pad
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // status, entry_total, key_out, zero pad
);

	dp_cmd_t                    cmd;
	dp_stat_t                   stat;
	logic [STAT_W-1:0]          status;
	logic [CW-1:0]              entry_total;
	logic signed [KEY_BITS-1:0] key_out;

	odle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	odle_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.CW       (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (s_axis_tdata[MODE_W-1:0]),
		.in_key     (s_axis_tdata[MODE_W +: KEY_BITS]),
		.in_pos     (s_axis_tdata[MODE_W + KEY_BITS +: POS_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_total  (entry_total),
		.out_key    (key_out)
	);

	assign m_axis_tdata = OUT_W'({key_out, entry_total, status});

endmodule

FILE: rtl/odle_ctrl.sv
// Controller for the ordered deque list engine.
// Sequences each request through the datapath by command; uses odle_pkg.
module odle_ctrl
	import odle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = CMD_ACCEPT;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				case (stat.mode)
					MODE_CLEAR: cmd = CMD_CLEAR;
					MODE_REVERSE: cmd = CMD_REVERSE;
					MODE_ORD_INS, MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
						if (stat.full) begin
							cmd = CMD_SET_FULL;
						end else begin
							cmd     = CMD_ALLOC;
							state_d = S_ALLOC_WR;
						end
					end
					MODE_DELETE, MODE_POP_FRONT: begin
						if (stat.count_zero) begin
							cmd = CMD_SET_EMPTY;
						end else begin
							cmd     = CMD_GO_FRONT;
							state_d = S_WALK;
						end
					end
					MODE_POP_BACK: begin
						if (stat.count_zero) begin
							cmd = CMD_SET_EMPTY;
						end else begin
							cmd     = CMD_GO_BACK;
							state_d = S_WALK;
						end
					end
					MODE_READ: begin
						if (stat.pos_bad) begin
							cmd = CMD_SET_BADPOS;
						end else begin
							cmd     = CMD_GO_FRONT;
							state_d = S_WALK;
						end
					end
					default: cmd = CMD_NONE;
				endcase
			end
			S_ALLOC_WR: begin
				cmd = CMD_ALLOC_WR;
				if (stat.mode == MODE_PUSH_BACK || stat.count_zero) begin
					state_d = S_APPEND;
				end else if (stat.mode == MODE_PUSH_FRONT) begin
					state_d = S_FRONT;
				end else begin
					state_d = S_WALK_GO;
				end
			end
			S_WALK_GO: begin
				cmd     = CMD_GO_FRONT;
				state_d = S_WALK;
			end
			S_FRONT: begin
				cmd     = CMD_GO_FRONT;
				state_d = S_INS_A;
			end
			S_WALK: begin
				if (stat.hit) begin
					if (stat.mode == MODE_ORD_INS) begin
						state_d = S_INS_A;
					end else if (stat.mode == MODE_READ) begin
						cmd     = CMD_HIT_READ;
						state_d = S_FIN;
					end else begin
						state_d = S_REMOVE;
					end
				end else if (stat.last) begin
					if (stat.mode == MODE_ORD_INS) begin
						state_d = S_APPEND;
					end else begin
						cmd     = CMD_NOTFOUND;
						state_d = S_FIN;
					end
				end else begin
					cmd = CMD_STEP;
				end
			end
			S_INS_A: begin
				cmd     = CMD_INS_A;
				state_d = stat.idx_zero ? S_FIN : S_INS_B;
			end
			S_INS_B: begin
				cmd     = CMD_INS_B;
				state_d = S_FIN;
			end
			S_APPEND: begin
				cmd     = CMD_APPEND;
				state_d = S_FIN;
			end
			S_REMOVE: begin
				cmd     = CMD_REMOVE;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd     = CMD_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: rtl/odle_dp.sv
// Datapath for the ordered deque list engine: key and link memories, slot
// allocator, list end registers, walk registers and the result register.
// Driven by odle_ctrl commands; uses odle_pkg.
module odle_dp
	import odle_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32,
	parameter int CW       = $clog2(CAPACITY + 1),
	parameter int SW       = $clog2(CAPACITY)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic [MODE_W-1:0]          in_mode,
	input  logic signed [KEY_BITS-1:0] in_key,
	input  logic [POS_W-1:0]           in_pos,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STAT_W-1:0]          out_status,
	output logic [CW-1:0]              out_total,
	output logic signed [KEY_BITS-1:0] out_key
);

	localparam int CMPW = CW + POS_W;

	logic [KEY_BITS-1:0] key_mem  [CAPACITY];
	logic [SW-1:0]       next_mem [CAPACITY];
	logic [SW-1:0]       prev_mem [CAPACITY];
	logic [SW-1:0]       free_mem [CAPACITY];

	logic [MODE_W-1:0]          mode_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [POS_W-1:0]           pos_q;
	logic [SW-1:0]              head_q, tail_q;
	logic [CW-1:0]              count_q, fresh_q, ftop_q, i_q;
	logic                       rev_q, use_free_q;
	logic [SW-1:0]              s_q, p_q, x_q, free_rd_q;
	logic signed [KEY_BITS-1:0] rd_key_q;
	logic [SW-1:0]              rd_next_q, rd_prev_q;
	logic [STAT_W-1:0]          res_status_q;
	logic signed [KEY_BITS-1:0] res_key_q;
	logic                       out_valid_q;
	logic [STAT_W-1:0]          out_status_q;
	logic [CW-1:0]              out_total_q;
	logic signed [KEY_BITS-1:0] out_key_q;

	logic [SW-1:0] front, back, lnext_rd, lprev_rd, x_w, rd_addr;
	logic          rd_en, ln_we, lp_we;
	logic [SW-1:0] ln_addr, ln_data, lp_addr, lp_data;
	logic          hit;

	assign front    = rev_q ? tail_q : head_q;
	assign back     = rev_q ? head_q : tail_q;
	assign lnext_rd = rev_q ? rd_prev_q : rd_next_q;
	assign lprev_rd = rev_q ? rd_next_q : rd_prev_q;
	assign x_w      = use_free_q ? free_rd_q : x_q;

	always_comb begin
		case (mode_q)
			MODE_ORD_INS: hit = rd_key_q >= key_q;
			MODE_DELETE:  hit = rd_key_q == key_q;
			MODE_READ:    hit = CMPW'(i_q) == CMPW'(pos_q);
			default:      hit = 1'b1;
		endcase
	end

	assign stat.mode       = mode_q;
	assign stat.count_zero = count_q == '0;
	assign stat.full       = count_q == CW'(CAPACITY);
	assign stat.pos_bad    = CMPW'(pos_q) >= CMPW'(count_q);
	assign stat.hit        = hit;
	assign stat.last       = CW'(i_q + 1'b1) == count_q;
	assign stat.idx_zero   = i_q == '0;
	assign stat.out_busy   = out_valid_q && !out_ready;

	// Read port: start of a walk or the next link of the node just read
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = lnext_rd;
		case (cmd)
			CMD_GO_FRONT: rd_addr = front;
			CMD_GO_BACK:  rd_addr = back;
			CMD_STEP:     rd_addr = lnext_rd;
			default:      rd_en   = 1'b0;
		endcase
	end

	// One write per logical link array per cycle
	always_comb begin
		ln_we   = 1'b0;
		lp_we   = 1'b0;
		ln_addr = x_q;
		ln_data = s_q;
		lp_addr = s_q;
		lp_data = x_q;
		case (cmd)
			CMD_INS_A: begin
				ln_we = 1'b1;
				lp_we = 1'b1;
			end
			CMD_INS_B: begin
				ln_we   = 1'b1;
				lp_we   = 1'b1;
				ln_addr = p_q;
				ln_data = x_q;
				lp_addr = x_q;
				lp_data = p_q;
			end
			CMD_APPEND: begin
				ln_we   = count_q != '0;
				lp_we   = count_q != '0;
				ln_addr = back;
				ln_data = x_q;
				lp_addr = x_q;
				lp_data = back;
			end
			CMD_REMOVE: begin
				// unlink a middle node only
				ln_we   = count_q > CW'(1) && i_q != '0 && CW'(i_q + 1'b1) != count_q;
				lp_we   = ln_we;
				ln_addr = lprev_rd;
				ln_data = lnext_rd;
				lp_addr = lnext_rd;
				lp_data = lprev_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q  <= key_mem[rd_addr];
			rd_next_q <= next_mem[rd_addr];
			rd_prev_q <= prev_mem[rd_addr];
		end
		if (cmd == CMD_ALLOC) begin
			free_rd_q <= free_mem[SW'(ftop_q - 1'b1)];
		end
		if (cmd == CMD_ALLOC_WR) begin
			key_mem[x_w] <= key_q;
		end
		if (cmd == CMD_REMOVE) begin
			free_mem[ftop_q[SW-1:0]] <= s_q;
		end
		if (ln_we) begin
			if (rev_q) begin
				prev_mem[ln_addr] <= ln_data;
			end else begin
				next_mem[ln_addr] <= ln_data;
			end
		end
		if (lp_we) begin
			if (rev_q) begin
				next_mem[lp_addr] <= lp_data;
			end else begin
				prev_mem[lp_addr] <= lp_data;
			end
		end
	end

	// Request, walk and result payload
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				mode_q       <= in_mode;
				key_q        <= in_key;
				pos_q        <= in_pos;
				res_status_q <= STAT_OK;
				res_key_q    <= '0;
			end
			CMD_SET_FULL:   res_status_q <= STAT_FULL;
			CMD_SET_EMPTY:  res_status_q <= STAT_EMPTY;
			CMD_SET_BADPOS: res_status_q <= STAT_BAD_POS;
			CMD_NOTFOUND:   res_status_q <= STAT_NOT_FOUND;
			CMD_HIT_READ:   res_key_q    <= rd_key_q;
			CMD_REMOVE:     res_key_q    <= rd_key_q;
			CMD_ALLOC:      x_q          <= fresh_q[SW-1:0];
			CMD_ALLOC_WR:   x_q          <= x_w;
			CMD_GO_FRONT: begin
				s_q <= front;
				i_q <= '0;
			end
			CMD_GO_BACK: begin
				s_q <= back;
				i_q <= CW'(count_q - 1'b1);
			end
			CMD_STEP: begin
				p_q <= s_q;
				s_q <= lnext_rd;
				i_q <= CW'(i_q + 1'b1);
			end
			CMD_FIN: begin
				out_status_q <= res_status_q;
				out_total_q  <= count_q;
				out_key_q    <= res_key_q;
			end
			default: ;
		endcase
	end

	// List control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			fresh_q     <= '0;
			ftop_q      <= '0;
			use_free_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the one just taken
			if (cmd == CMD_FIN) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_CLEAR: begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
					rev_q   <= 1'b0;
					fresh_q <= '0;
					ftop_q  <= '0;
				end
				CMD_REVERSE: rev_q <= !rev_q;
				CMD_ALLOC: begin
					// recycle a returned slot first, else hand out a fresh one
					use_free_q <= ftop_q != '0;
					if (ftop_q != '0) begin
						ftop_q <= CW'(ftop_q - 1'b1);
					end else begin
						fresh_q <= CW'(fresh_q + 1'b1);
					end
				end
				CMD_INS_A: begin
					count_q <= CW'(count_q + 1'b1);
					if (i_q == '0) begin
						if (rev_q) tail_q <= x_q; else head_q <= x_q;
					end
				end
				CMD_APPEND: begin
					count_q <= CW'(count_q + 1'b1);
					if (rev_q) head_q <= x_q; else tail_q <= x_q;
					if (count_q == '0) begin
						if (rev_q) tail_q <= x_q; else head_q <= x_q;
					end
				end
				CMD_REMOVE: begin
					count_q <= CW'(count_q - 1'b1);
					ftop_q  <= CW'(ftop_q + 1'b1);
					if (count_q > CW'(1)) begin
						if (i_q == '0) begin
							if (rev_q) tail_q <= lnext_rd; else head_q <= lnext_rd;
						end else if (CW'(i_q + 1'b1) == count_q) begin
							if (rev_q) head_q <= lprev_rd; else tail_q <= lprev_rd;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_total  = out_total_q;
	assign out_key    = out_key_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_slots_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(count_q) + (CW + 1)'(ftop_q) <= (CW + 1)'(fresh_q))
		else $error("more slots in use or returned than handed out");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CW'(CAPACITY))
		else $error("fresh slot counter beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_CLEAR |=> count_q == '0 && ftop_q == '0)
		else $error("clear left entries behind");

endmodule

FILE: dv/ordered_deque_list_engine_unit_test.sv
// Testbench for the ordered deque list engine: directed and random requests over the stream ports.
// A scoreboard class keeps a queue-based copy of the list and checks every result in order.
// Depends on odle_pkg and ordered_deque_list_engine_unit.
`timescale 1ns / 100ps

module ordered_deque_list_engine_unit_test;
	import odle_pkg::*;

	localparam int CAP   = 64;
	localparam int IN_W  = 48;
	localparam int OUT_W = 48;

	// last member sits in the lowest bits
	typedef struct packed {
		logic [31:0]       key_out;
		logic [6:0]        entry_total;
		logic [STAT_W-1:0] status;
	} list_result_t;

	class list_scoreboard;
		logic signed [31:0] entries[$];
		list_result_t       pending[$];
		int                 failures;
		int                 checked;

		function void note_request(logic [3:0] mode, logic signed [31:0] key, logic [5:0] pos);
			list_result_t r;
			int           i;
			bit           done;
			r.status  = STAT_OK;
			r.key_out = '0;
			done      = 0;
			case (mode)
				MODE_CLEAR: entries.delete();
				MODE_ORD_INS: begin
					if (entries.size() >= CAP) begin
						r.status = STAT_FULL;
					end else begin
						for (i = 0; i < entries.size() && !done; i++) begin
							if (entries[i] >= key) begin
								entries.insert(i, key);
								done = 1;
							end
						end
						if (!done) entries.push_back(key);
					end
				end
				MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
					if (entries.size() >= CAP) r.status = STAT_FULL;
					else if (mode == MODE_PUSH_BACK) entries.push_back(key);
					else entries.push_front(key);
				end
				MODE_DELETE: begin
					if (entries.size() == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						r.status = STAT_NOT_FOUND;
						for (i = 0; i < entries.size() && !done; i++) begin
							if (entries[i] == key) begin
								r.key_out = entries[i];
								entries.delete(i);
								r.status = STAT_OK;
								done = 1;
							end
						end
					end
				end
				MODE_POP_BACK: begin
					if (entries.size() == 0) r.status = STAT_EMPTY;
					else r.key_out = entries.pop_back();
				end
				MODE_POP_FRONT: begin
					if (entries.size() == 0) r.status = STAT_EMPTY;
					else r.key_out = entries.pop_front();
				end
				MODE_REVERSE: entries.reverse();
				MODE_READ: begin
					if (pos >= entries.size()) r.status = STAT_BAD_POS;
					else r.key_out = entries[pos];
				end
				default: ;
			endcase
			r.entry_total = 7'(entries.size());
			pending.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			list_result_t want;
			list_result_t got;
			got = data[STAT_W+7+32-1:0];
			if (pending.size() == 0) begin
				$error("result with no request outstanding: %h", data);
				failures++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.entry_total !== want.entry_total) begin
				$error("entry_total: expected %0d, actual %0d", want.entry_total,
					got.entry_total);
				failures++;
			end
			if (got.key_out !== want.key_out) begin
				$error("key_out: expected %0d, actual %0d", $signed(want.key_out),
					$signed(got.key_out));
				failures++;
			end
			if (data[OUT_W-1:STAT_W+7+32] !== '0) begin
				$error("pad: expected 0, actual %h", data[OUT_W-1:STAT_W+7+32]);
				failures++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;   // mode, key, position, zero pad
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // status, entry_total, key_out, zero pad

	list_scoreboard board;
	bit             calm;
	bit             hold_sink;
	int             sent;
	int             mode_seen[16];

	ordered_deque_list_engine_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_request(logic [3:0] mode, logic signed [31:0] key, logic [5:0] pos);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {6'b000000, pos, key, mode};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_request(mode, key, pos);
		mode_seen[mode]++;
		sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15) - 8;
			1: return 32'sh7fffffff - $urandom_range(0, 2);
			2: return 32'sh80000000 + $urandom_range(0, 2);
			default: return $urandom;
		endcase
	endfunction

	// Sink: random stalls, one long hold-off when asked.
	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_sink = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				m_axis_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
		end
	end

	initial begin
		int i;
		int n;
		logic [3:0] m;
		board         = new();
		calm          = 0;
		hold_sink     = 0;
		arst_n        = 0;
		s_axis_tvalid = 0;
		s_axis_tdata  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty-store cases, extremes, reverse, full store.
		send_request(MODE_POP_FRONT, 0, 0);
		send_request(MODE_POP_BACK, 0, 0);
		send_request(MODE_DELETE, 5, 0);
		send_request(MODE_READ, 0, 0);
		send_request(MODE_REVERSE, 0, 0);
		send_request(MODE_ORD_INS, 32'sh7fffffff, 0);
		send_request(MODE_ORD_INS, 32'sh80000000, 0);
		send_request(MODE_ORD_INS, 0, 0);
		send_request(MODE_ORD_INS, 0, 0);
		send_request(MODE_PUSH_FRONT, -1, 0);
		send_request(MODE_PUSH_BACK, 1, 0);
		send_request(MODE_DELETE, 12345, 0);
		send_request(MODE_READ, 0, 63);
		send_request(MODE_REVERSE, 0, 0);
		send_request(MODE_READ, 0, 1);
		send_request(MODE_DELETE, 0, 0);
		send_request(MODE_POP_BACK, 0, 0);
		send_request(MODE_POP_FRONT, 0, 0);
		send_request(4'd9, -1, 6'h3f);
		send_request(4'd15, 0, 0);
		send_request(MODE_CLEAR, 0, 0);
		for (i = 0; i < CAP; i++) send_request(MODE_PUSH_BACK, pick_key(), 0);
		send_request(MODE_ORD_INS, 0, 0);
		send_request(MODE_PUSH_FRONT, 0, 0);
		send_request(MODE_READ, 0, 63);
		// Sender pauses until every result is in.
		wait_drained();
		repeat (80) @(posedge clk);
		send_request(MODE_CLEAR, 0, 0);

		// Random: weighted mix of all modes and unused codes; the list length wanders.
		for (i = 0; i < 900; i++) begin
			if (i == 300) hold_sink = 1;
			if (i == 800) calm = 1;
			n = $urandom_range(0, 99);
			if (n < 1) m = MODE_CLEAR;
			else if (n < 2) m = 4'($urandom_range(9, 15));
			else if (n < 22) m = MODE_ORD_INS;
			else if (n < 32) m = MODE_PUSH_BACK;
			else if (n < 42) m = MODE_PUSH_FRONT;
			else if (n < 57) m = MODE_DELETE;
			else if (n < 65) m = MODE_POP_BACK;
			else if (n < 73) m = MODE_POP_FRONT;
			else if (n < 78) m = MODE_REVERSE;
			else m = MODE_READ;
			if (m == MODE_DELETE && board.entries.size() > 0 && $urandom_range(0, 1))
				send_request(m, board.entries[$urandom_range(0, board.entries.size() - 1)],
					6'($urandom));
			else
				send_request(m, pick_key(), 6'($urandom));
		end

		wait_drained();
		repeat (100) @(posedge clk);
		$display("Covered %0d requests, %0d results checked; ordered inserts %0d, deletes %0d, reads %0d.",
			sent, board.checked, mode_seen[MODE_ORD_INS], mode_seen[MODE_DELETE],
			mode_seen[MODE_READ]);
		if (board.failures == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
